// ===== hdl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int QUEUE_DEPTH     = 16;
  localparam int PRIORITY_LEVELS = 8;

  localparam int TASK_W  = 8;
  localparam int PRIO_W  = 3;
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = TASK_W + PRIO_W;

  localparam logic [PRIO_W-1:0] PRIO_MAX = PRIO_W'(PRIORITY_LEVELS - 1);

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SHIFT,
    S_INSERT,
    S_TOP,
    S_CAPTURE
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_rd;
    logic shift_init;
    logic shift_rd;
    logic ins_wr;
    logic top_rd;
    logic capture;
  } cmd_t;

  typedef struct packed {
    logic do_insert;
    logic scan_end;
    logic cmp_pend;
    logic shift_end;
    logic wr_pend;
    logic res_free;
  } sts_t;

  function automatic logic [PRIO_W-1:0] sat_prio(input logic [PRIO_W-1:0] p);
    if (p > PRIO_MAX) begin
      return PRIO_MAX;
    end
    return p;
  endfunction

endpackage

// ===== hdl/spq_ctrl.sv =====
// Sequencer for the sorted priority queue: scan, shift, insert, read top, report.
// Depends on spq_pkg for the state, command and status types.
`timescale 1ns / 1ps
module spq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spq_pkg::sts_t sts,
  output spq_pkg::cmd_t cmd
);
  import spq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = sts.do_insert ? S_SCAN : S_TOP;
      end
      S_SCAN: begin
        if (!sts.scan_end) begin
          cmd.scan_rd = 1'b1;
        end else if (!sts.cmp_pend) begin
          cmd.shift_init = 1'b1;
          state_next     = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!sts.shift_end) begin
          cmd.shift_rd = 1'b1;
        end else if (!sts.wr_pend) begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.ins_wr = 1'b1;
        state_next = S_TOP;
      end
      S_TOP: begin
        cmd.top_rd = 1'b1;
        state_next = S_CAPTURE;
      end
      S_CAPTURE: begin
        if (sts.res_free) begin
          cmd.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/spq_dpath.sv =====
// Datapath for the sorted priority queue: slot memory, counters and result register.
// Depends on spq_pkg; driven by commands from spq_ctrl.
`timescale 1ns / 1ps
module spq_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  spq_pkg::cmd_t               cmd,
  output spq_pkg::sts_t               sts,
  input  logic                        req_type,
  input  logic [spq_pkg::TASK_W-1:0]  task_id,
  input  logic [spq_pkg::PRIO_W-1:0]  task_priority,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [spq_pkg::TASK_W-1:0]  out_task,
  output logic [spq_pkg::PRIO_W-1:0]  out_priority,
  output logic                        out_valid,
  output logic [spq_pkg::CNT_W-1:0]   entry_count,
  output spq_pkg::status_t            status
);
  import spq_pkg::*;

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];

  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   pos;
  logic               req_pop;
  logic [TASK_W-1:0]  tid;
  logic [PRIO_W-1:0]  prio;
  status_t            op_status;
  logic               cmp_pend;
  logic               wr_pend;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] rd_q;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_a;
  logic [ENTRY_W-1:0] wr_d;
  logic [CNT_W-1:0]   idx_dec;
  logic [CNT_W-1:0]   fill_dec;
  logic               pop_ok;

  assign idx_dec  = idx - CNT_W'(1);
  assign fill_dec = fill - CNT_W'(1);
  assign pop_ok   = req_pop && (op_status == ST_OK);

  always_comb begin
    rd_en   = cmd.scan_rd | cmd.shift_rd | cmd.top_rd;
    rd_addr = idx[IDX_W-1:0];
    if (cmd.shift_rd) begin
      rd_addr = idx_dec[IDX_W-1:0];
    end else if (cmd.top_rd) begin
      rd_addr = fill_dec[IDX_W-1:0];
    end
    wr_en = wr_pend | cmd.ins_wr;
    wr_a  = wr_pend ? wr_addr : pos[IDX_W-1:0];
    wr_d  = wr_pend ? rd_q : {tid, prio};
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_a] <= wr_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      cmp_pend  <= 1'b0;
      wr_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      cmp_pend <= cmd.scan_rd;
      wr_pend  <= cmd.shift_rd;
      if (cmd.ins_wr) begin
        fill <= fill + CNT_W'(1);
      end else if (cmd.capture && pop_ok) begin
        fill <= fill_dec;
      end
      if (cmd.capture) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_pop <= (req_type == REQ_POP);
      tid     <= task_id;
      prio    <= sat_prio(task_priority);
      idx     <= '0;
      pos     <= '0;
      if (req_type == REQ_POP && fill == '0) begin
        op_status <= ST_EMPTY;
      end else if (req_type == REQ_PUSH && fill == CNT_W'(QUEUE_DEPTH)) begin
        op_status <= ST_FULL;
      end else begin
        op_status <= ST_OK;
      end
    end
    if (cmd.scan_rd) begin
      idx <= idx + CNT_W'(1);
    end
    if (cmd.shift_init) begin
      idx <= fill;
    end
    if (cmd.shift_rd) begin
      idx     <= idx_dec;
      wr_addr <= idx[IDX_W-1:0];
    end
    if (cmp_pend && (rd_q[PRIO_W-1:0] < prio)) begin
      pos <= pos + CNT_W'(1);
    end
    if (cmd.capture) begin
      status      <= op_status;
      entry_count <= pop_ok ? fill_dec : fill;
      if (fill != '0) begin
        out_task     <= rd_q[ENTRY_W-1:PRIO_W];
        out_priority <= rd_q[PRIO_W-1:0];
        out_valid    <= 1'b1;
      end else begin
        out_task     <= '0;
        out_priority <= '0;
        out_valid    <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.do_insert = !req_pop && (op_status == ST_OK);
    sts.scan_end  = (idx == fill);
    sts.cmp_pend  = cmp_pend;
    sts.shift_end = (idx == pos);
    sts.wr_pend   = wr_pend;
    sts.res_free  = !rsp_valid || rsp_ready;
  end

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl and spq_dpath.
//
//   channel  handshake              beat contents
//   req      req_valid/req_ready    req_type, task_id, task_priority
//   rsp      rsp_valid/rsp_ready    out_task, out_priority, out_valid, entry_count, status
//
// A pop, or a rejected request, passes through the check, top read and capture states
// from accept to result. An enqueue first scans the slots for its position, one slot
// memory read per cycle for the priority scan, then does one read and one write per
// cycle for the shift up, and then writes the new entry into the freed slot.
// Reset empties the queue at once; slot contents are left as they are.
// A result waiting on rsp_ready does not block the next request, but the capture
// of the following result holds until the output register is free.
`timescale 1ns / 1ps
module sorted_priority_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic                        req_type,
  input  logic [spq_pkg::TASK_W-1:0]  task_id,
  input  logic [spq_pkg::PRIO_W-1:0]  task_priority,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [spq_pkg::TASK_W-1:0]  out_task,
  output logic [spq_pkg::PRIO_W-1:0]  out_priority,
  output logic                        out_valid,
  output logic [spq_pkg::CNT_W-1:0]   entry_count,
  output spq_pkg::status_t            status
);
  import spq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  spq_dpath u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_type      (req_type),
    .task_id       (task_id),
    .task_priority (task_priority),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .out_task      (out_task),
    .out_priority  (out_priority),
    .out_valid     (out_valid),
    .entry_count   (entry_count),
    .status        (status)
  );

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_wr |-> !sts.wr_pend)
    else $error("insert write collides with pending shift write");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> entry_count <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_full_report: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_FULL) |-> (out_valid && entry_count == CNT_W'(QUEUE_DEPTH)))
    else $error("full status without full queue");

  a_empty_report: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_EMPTY) |-> (!out_valid && entry_count == '0))
    else $error("empty status with entries reported");

endmodule
